// File: rtl/dhte_pkg.sv
// Package with the command and status codes of the delivery hash table engine.
`timescale 1ns / 1ps
package dhte_pkg;
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_INVALID = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_NO_FREE = 2'd2;
   localparam logic [1:0] ST_BUCKET_FULL = 2'd3;

   localparam logic [31:0] HASH_MULT = 32'd2654435761;

   // One queued command word after the hash stage.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] client;
      logic [15:0] msg_num;
      logic [15:0] bucket;
   } dhte_cmd_type;
endpackage

// File: rtl/dhte_front.sv
// Front end: takes command words, hashes the key and queues them for the back end.
`timescale 1ns / 1ps
module dhte_front
   import dhte_pkg::*;
#(
   parameter int HASH_BITS = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_cmd,
   input  logic [15:0]  req_client,
   input  logic [15:0]  req_msg_num,
   output logic         req_full,
   output logic         q_valid,
   output dhte_cmd_type q_data,
   input  logic         q_pop
);
   logic [31:0]  prod;
   logic         stg_valid_ff, stg_valid_in;
   logic [1:0]   stg_cmd_ff;
   logic [31:0]  stg_prod_ff;
   logic [15:0]  stg_client_ff, stg_msg_ff;
   dhte_cmd_type q_data_ff [2];
   logic         q_wp_ff, q_rp_ff;
   logic [1:0]   q_cnt_ff;
   logic         push;

   assign prod = {req_client, req_msg_num} * HASH_MULT;
   // Only one word may be anywhere in the front at once, in the staging register or the queue.
   assign req_full = stg_valid_ff || (q_cnt_ff != 2'd0);
   assign push = stg_valid_ff;
   assign stg_valid_in = req_valid && !req_full;
   assign q_valid = (q_cnt_ff != 2'd0);
   assign q_data = q_data_ff[q_rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         q_wp_ff <= 1'b0;
         q_rp_ff <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         if (push) q_wp_ff <= ~q_wp_ff;
         if (q_pop) q_rp_ff <= ~q_rp_ff;
         q_cnt_ff <= q_cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
      if (stg_valid_in) begin
         stg_cmd_ff <= req_cmd;
         stg_prod_ff <= prod;
         stg_client_ff <= req_client;
         stg_msg_ff <= req_msg_num;
      end
      if (push) begin
         q_data_ff[q_wp_ff].cmd <= stg_cmd_ff;
         q_data_ff[q_wp_ff].client <= stg_client_ff;
         q_data_ff[q_wp_ff].msg_num <= stg_msg_ff;
         q_data_ff[q_wp_ff].bucket <= 16'(stg_prod_ff >> (32 - HASH_BITS));
      end
   end

   assert property (@(posedge clock) disable iff (reset) q_cnt_ff != 2'd3)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) stg_valid_ff |=> !stg_valid_ff)
      else $error("hash stage took two words");
endmodule

// File: rtl/dhte_back.sv
// Back end: sequencer that runs insert, lookup and remove on the table memories.
`timescale 1ns / 1ps
module dhte_back
   import dhte_pkg::*;
#(
   parameter int SLOTS = 1024,
   parameter int HASH_BITS = 13,
   parameter int BUCKET_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  dhte_cmd_type q_data,
   output logic         q_pop,
   output logic         busy,
   output logic         rsp_valid,
   output logic [1:0]   rsp_status,
   output logic [9:0]   rsp_slot_index
);
   localparam int SW = $clog2(SLOTS);
   localparam int LW = SW + 1;
   localparam int NB = 1 << HASH_BITS;
   localparam int DW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int CW = $clog2(BUCKET_DEPTH + 1);
   localparam int EW = HASH_BITS + DW;
   localparam int INIT_N = (NB > SLOTS) ? NB : SLOTS;
   localparam int IW = $clog2(INIT_N + 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_RD, S_WAIT, S_DEC, S_SCAN_RD, S_SCAN_KEY, S_SCAN_CHK,
      S_SHIFT_RD, S_SHIFT_WR, S_DONE
   } state_type;

   logic [LW-1:0] link_mem [SLOTS];
   logic [31:0]   key_mem [SLOTS];
   logic [CW-1:0] cnt_mem [NB];
   logic [SW-1:0] ent_mem [1 << EW];

   state_type     state_ff;
   logic [LW-1:0] head_ff;
   logic [IW-1:0] init_ff;
   dhte_cmd_type  cur_ff;
   logic [CW-1:0] cnt_ff;
   logic [LW-1:0] link_rd_ff;
   logic [CW-1:0] cnt_rd_ff;
   logic [SW-1:0] ent_rd_ff;
   logic [31:0]   key_rd_ff;
   logic [CW-1:0] pos_ff;
   logic [SW-1:0] found_ff;
   logic [1:0]    st_ff;
   logic [9:0]    slot_ff;
   logic          rv_ff;

   logic [HASH_BITS-1:0] bkt;
   logic [EW-1:0] ent_addr;
   logic [SW-1:0] link_addr, key_addr;
   logic          link_we, key_we, cnt_we, ent_we;
   logic [LW-1:0] link_wd;
   logic [CW-1:0] cnt_wd;
   logic [SW-1:0] ent_wd;
   logic [HASH_BITS-1:0] cnt_addr;

   assign bkt = cur_ff.bucket[HASH_BITS-1:0];
   assign busy = (state_ff != S_IDLE);
   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_slot_index = slot_ff;

   // Memory port control, decided by state.
   always_comb begin
      link_we = 1'b0; key_we = 1'b0; cnt_we = 1'b0; ent_we = 1'b0;
      link_addr = head_ff[SW-1:0];
      link_wd = head_ff;
      key_addr = ent_rd_ff;
      cnt_addr = bkt;
      cnt_wd = cnt_ff;
      ent_addr = {bkt, pos_ff[DW-1:0]};
      ent_wd = ent_rd_ff;
      case (state_ff)
         S_INIT: begin
            cnt_addr = init_ff[HASH_BITS-1:0];
            cnt_wd = '0;
            cnt_we = 1'b1;
            link_addr = SW'(init_ff);
            link_wd = LW'(init_ff) + LW'(1);
            link_we = (init_ff < IW'(SLOTS));
         end
         S_DEC: begin
            if (cur_ff.cmd == CMD_INSERT && head_ff < LW'(SLOTS) &&
                cnt_rd_ff < CW'(BUCKET_DEPTH)) begin
               key_addr = head_ff[SW-1:0];
               key_we = 1'b1;
               cnt_wd = cnt_rd_ff + CW'(1);
               cnt_we = 1'b1;
               ent_addr = {bkt, cnt_rd_ff[DW-1:0]};
               ent_wd = head_ff[SW-1:0];
               ent_we = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            ent_addr = {bkt, DW'(pos_ff + CW'(1))};
         end
         S_SHIFT_WR: begin
            ent_we = 1'b1;
            if (pos_ff + CW'(1) >= cnt_ff) begin
               cnt_wd = cnt_ff - CW'(1);
               cnt_we = 1'b1;
               link_addr = found_ff;
               link_wd = head_ff;
               link_we = 1'b1;
               ent_we = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_addr] <= link_wd;
      link_rd_ff <= link_mem[link_addr];
      if (key_we) key_mem[key_addr] <= {cur_ff.client, cur_ff.msg_num};
      key_rd_ff <= key_mem[key_addr];
      if (cnt_we) cnt_mem[cnt_addr] <= cnt_wd;
      cnt_rd_ff <= cnt_mem[cnt_addr];
      if (ent_we) ent_mem[ent_addr] <= ent_wd;
      ent_rd_ff <= ent_mem[ent_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff <= '0;
         head_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= 1'b0;
         case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + IW'(1);
               if (init_ff == IW'(INIT_N - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (q_valid) begin
               cur_ff <= q_data;
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_WAIT;
            S_WAIT: state_ff <= S_DEC;
            S_DEC: begin
               cnt_ff <= (cnt_rd_ff > CW'(BUCKET_DEPTH)) ? CW'(BUCKET_DEPTH) : cnt_rd_ff;
               pos_ff <= '0;
               st_ff <= ST_NOT_FOUND;
               slot_ff <= '0;
               state_ff <= S_DONE;
               case (cur_ff.cmd)
                  CMD_INSERT: begin
                     if (head_ff >= LW'(SLOTS)) st_ff <= ST_NO_FREE;
                     else if (cnt_rd_ff >= CW'(BUCKET_DEPTH)) st_ff <= ST_BUCKET_FULL;
                     else begin
                        st_ff <= ST_OK;
                        slot_ff <= 10'(head_ff);
                        head_ff <= link_rd_ff;
                     end
                  end
                  CMD_LOOKUP, CMD_REMOVE: state_ff <= S_SCAN_RD;
                  default: ;
               endcase
            end
            S_SCAN_RD: begin
               // The entry at pos is read here, its key in the next cycle.
               if (pos_ff >= cnt_ff) state_ff <= S_DONE;
               else state_ff <= S_SCAN_KEY;
            end
            S_SCAN_KEY: state_ff <= S_SCAN_CHK;
            S_SCAN_CHK: begin
               if (key_rd_ff == {cur_ff.client, cur_ff.msg_num} &&
                   LW'(ent_rd_ff) < LW'(SLOTS)) begin
                  st_ff <= ST_OK;
                  slot_ff <= 10'(ent_rd_ff);
                  found_ff <= ent_rd_ff;
                  if (cur_ff.cmd == CMD_REMOVE) state_ff <= S_SHIFT_RD;
                  else state_ff <= S_DONE;
               end else begin
                  pos_ff <= pos_ff + CW'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SHIFT_RD: state_ff <= S_SHIFT_WR;
            S_SHIFT_WR: begin
               if (pos_ff + CW'(1) >= cnt_ff) begin
                  head_ff <= LW'(found_ff);
                  state_ff <= S_DONE;
               end else begin
                  pos_ff <= pos_ff + CW'(1);
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_DONE: begin
               rv_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rv_ff && st_ff != ST_OK |-> slot_ff == '0) else $error("slot nonzero on failure");
   assert property (@(posedge clock) disable iff (reset)
      rv_ff |=> !rv_ff) else $error("result repeated");
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == S_RD) else $error("pop without start");
endmodule

// File: rtl/delivery_hash_table_engine_unit.sv
// Top level of the delivery hash table engine.
`timescale 1ns / 1ps
// Usage: raise start with req_cmd, req_client and req_msg_num; the word is taken
// at an edge where start is high and busy is low. Each command yields one result word
// on rsp_status and rsp_slot_index, marked by rsp_valid for one cycle; the receiver
// cannot stall it.
// An insert or an unknown command passes the staging register, the queue and the states
// S_RD, S_WAIT, S_DEC and S_DONE. Lookup and remove add S_SCAN_RD, S_SCAN_KEY and
// S_SCAN_CHK per entry compared, plus S_SCAN_RD when nothing matches; a matching remove
// adds S_SHIFT_RD, S_SHIFT_WR per shifted entry, again for count and free-list update.
// The back sequencer works on one command at a time; the staging register and the
// one-word queue take the next command while the previous one runs, so a new command
// can be taken before the previous result is out.
// After reset a clearing pass writes the bucket counts and free-list links, one entry
// a cycle for max(2^HASH_BITS, SLOTS) entries (8192 by default). One word may be taken
// during the pass; it waits in the queue and busy stays high until the pass ends.
module delivery_hash_table_engine_unit
   import dhte_pkg::*;
#(
   parameter int SLOTS = 1024,
   parameter int HASH_BITS = 13,
   parameter int BUCKET_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_client,
   input  logic [15:0] req_msg_num,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_slot_index
);
   dhte_cmd_type q_data;
   logic q_valid, q_pop, front_full, back_busy;

   assign busy = front_full || (back_busy && q_valid);

   dhte_front #(.HASH_BITS(HASH_BITS)) u_front (
      .clock, .reset, .req_valid(start), .req_cmd, .req_client, .req_msg_num,
      .req_full(front_full), .q_valid, .q_data, .q_pop
   );

   dhte_back #(.SLOTS(SLOTS), .HASH_BITS(HASH_BITS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_data, .q_pop, .busy(back_busy),
      .rsp_valid, .rsp_status, .rsp_slot_index
   );
endmodule
